// ===== hdl/tsrb_pkg.sv =====
// Shared types and constants of the timestamp reorder buffer.
package tsrb_pkg;

    localparam int TIME_W = 52;
    localparam int PAY_W  = 32;
    localparam int KIND_W = 2;

    localparam int DEF_WINDOW_DEPTH = 64;
    localparam int DEF_EMIT_BATCH   = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_EMIT  = 2'd0,
        KIND_LATE  = 2'd1,
        KIND_EMPTY = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_SHIFT  = 2'd2
    } t_cell_op;

    typedef struct packed {
        logic [TIME_W-1:0] tstamp;
        logic [PAY_W-1:0]  pay;
    } t_entry;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        t_cell_op          op;
        logic [TIME_W-1:0] key;
        logic [PAY_W-1:0]  pay;
    } t_cell_ctrl;

endpackage

// ===== hdl/tsrb_if.sv =====
// Valid/ready channel interfaces for the input and result items.
interface tsrb_in_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [tsrb_pkg::TIME_W-1:0] event_time;
    logic [tsrb_pkg::PAY_W-1:0]  payload;

    modport source (output valid, output action, output event_time, output payload,
                    input ready);
    modport sink   (input valid, input action, input event_time, input payload,
                    output ready);
endinterface

interface tsrb_out_if;
    logic                        valid;
    logic                        ready;
    logic [tsrb_pkg::KIND_W-1:0] kind;
    logic [tsrb_pkg::TIME_W-1:0] out_time;
    logic [tsrb_pkg::PAY_W-1:0]  out_payload;
    logic                        last;

    modport source (output valid, output kind, output out_time, output out_payload,
                    output last, input ready);
    modport sink   (input valid, input kind, input out_time, input out_payload,
                    input last, output ready);
endinterface

// ===== hdl/timestamp_reorder_buffer.sv =====
// Top level of the timestamp reorder buffer: sequencer, result register, sort chain.
//
// Usage:
//   i_in carries items {action, event_time, payload}; o_out carries results
//   {kind, out_time, out_payload, last}. Both are valid/ready channels.
//   An insert (action 0) drops into a chain of WINDOW_DEPTH cells, each
//   comparing the new time with its own entry in parallel, so the entry
//   lands after all equal or older ones in the same cycle. A drain
//   (action 1) shifts the chain toward cell 0 and emits the head, or an
//   empty marker when nothing is stored.
//   Flow: an item is taken while the sequencer is idle and the result register
//   is free or being read. Drains and late drops show their result in the cycle
//   after acceptance. An insert into a full window is latched on acceptance;
//   then min(EMIT_BATCH, WINDOW_DEPTH) heads are emitted, one per cycle while
//   the result register can load, and a final step stores or drops the insert.
//   The single-entry result register sets the pace: each result needs the output
//   free or read, and no new item is taken while a batch is in flight.
//   Reset clears the fill count, the emitted flag, the sequencer and the
//   result valid; cell contents are left as they are and never read while
//   unoccupied. A stalled receiver holds the result and freezes the chain.
module timestamp_reorder_buffer #(
    parameter int WINDOW_DEPTH = tsrb_pkg::DEF_WINDOW_DEPTH,
    parameter int EMIT_BATCH   = tsrb_pkg::DEF_EMIT_BATCH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tsrb_in_if.sink    i_in,
    tsrb_out_if.source o_out
);

    localparam int FILL_W    = $clog2(WINDOW_DEPTH + 1);
    localparam int BATCH_EFF = (EMIT_BATCH < WINDOW_DEPTH) ? EMIT_BATCH : WINDOW_DEPTH;
    localparam int CNT_W     = $clog2(BATCH_EFF + 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_EMIT   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    t_state                      r_state, n_state;
    logic [FILL_W-1:0]           r_fill, n_fill;
    logic                        r_has_emitted, n_has_emitted;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic [tsrb_pkg::TIME_W-1:0] r_key, n_key;
    logic [tsrb_pkg::PAY_W-1:0]  r_pay, n_pay;

    // Result register
    logic                        r_ov, n_ov;
    tsrb_pkg::t_kind             r_kind, n_kind;
    logic [tsrb_pkg::TIME_W-1:0] r_otime, n_otime;
    logic [tsrb_pkg::PAY_W-1:0]  r_opay, n_opay;
    logic                        r_last, n_last;

    tsrb_pkg::t_cell_ctrl        w_ctrl;
    tsrb_pkg::t_entry            w_head, w_second;
    logic                        w_can_load;
    logic                        w_in_fire;
    logic                        w_full;
    logic                        w_nonempty;
    logic [tsrb_pkg::TIME_W-1:0] w_key;
    logic [tsrb_pkg::PAY_W-1:0]  w_pay;
    logic                        w_late_head;

    assign w_can_load = !r_ov || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && w_can_load;
    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_full     = r_fill == FILL_W'(WINDOW_DEPTH);
    assign w_nonempty = r_fill != '0;

    // Key seen by the cells: live input when idle, the held insert otherwise.
    assign w_key = (r_state == S_IDLE) ? i_in.event_time : r_key;
    assign w_pay = (r_state == S_IDLE) ? i_in.payload    : r_pay;

    // Late only once something has left and only against a stored head.
    assign w_late_head = r_has_emitted && w_nonempty && (w_key < w_head.tstamp);

    always_comb begin
        n_state       = r_state;
        n_fill        = r_fill;
        n_has_emitted = r_has_emitted;
        n_cnt         = r_cnt;
        n_key         = r_key;
        n_pay         = r_pay;
        n_ov          = r_ov && !o_out.ready;
        n_kind        = r_kind;
        n_otime       = r_otime;
        n_opay        = r_opay;
        n_last        = r_last;
        w_ctrl.op     = tsrb_pkg::OP_HOLD;
        w_ctrl.key    = w_key;
        w_ctrl.pay    = w_pay;

        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    if (i_in.action) begin
                        n_ov   = 1'b1;
                        n_last = 1'b1;
                        if (w_nonempty) begin
                            n_kind        = tsrb_pkg::KIND_EMIT;
                            n_otime       = w_head.tstamp;
                            n_opay        = w_head.pay;
                            w_ctrl.op     = tsrb_pkg::OP_SHIFT;
                            n_fill        = r_fill - FILL_W'(1);
                            n_has_emitted = 1'b1;
                        end else begin
                            n_kind  = tsrb_pkg::KIND_EMPTY;
                            n_otime = '0;
                            n_opay  = '0;
                        end
                    end else if (w_full) begin
                        n_key   = i_in.event_time;
                        n_pay   = i_in.payload;
                        n_cnt   = '0;
                        n_state = S_EMIT;
                    end else if (w_late_head) begin
                        n_ov    = 1'b1;
                        n_kind  = tsrb_pkg::KIND_LATE;
                        n_otime = i_in.event_time;
                        n_opay  = i_in.payload;
                        n_last  = 1'b1;
                    end else begin
                        w_ctrl.op = tsrb_pkg::OP_INSERT;
                        n_fill    = r_fill + FILL_W'(1);
                    end
                end
            end
            S_EMIT: begin
                if (w_can_load) begin
                    n_ov          = 1'b1;
                    n_kind        = tsrb_pkg::KIND_EMIT;
                    n_otime       = w_head.tstamp;
                    n_opay        = w_head.pay;
                    n_last        = 1'b0;
                    w_ctrl.op     = tsrb_pkg::OP_SHIFT;
                    n_fill        = r_fill - FILL_W'(1);
                    n_has_emitted = 1'b1;
                    n_cnt         = r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(BATCH_EFF - 1)) begin
                        // Cell 1 becomes the head: if the held entry is late,
                        // the drop result closes the item instead.
                        n_last  = !((r_fill > FILL_W'(1)) && (r_key < w_second.tstamp));
                        n_state = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                if (w_can_load) begin
                    if (w_late_head) begin
                        n_ov    = 1'b1;
                        n_kind  = tsrb_pkg::KIND_LATE;
                        n_otime = r_key;
                        n_opay  = r_pay;
                        n_last  = 1'b1;
                    end else begin
                        w_ctrl.op = tsrb_pkg::OP_INSERT;
                        n_fill    = r_fill + FILL_W'(1);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_fill        <= '0;
            r_has_emitted <= 1'b0;
            r_cnt         <= '0;
            r_ov          <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_fill        <= n_fill;
            r_has_emitted <= n_has_emitted;
            r_cnt         <= n_cnt;
            r_ov          <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_pay   <= n_pay;
        r_kind  <= n_kind;
        r_otime <= n_otime;
        r_opay  <= n_opay;
        r_last  <= n_last;
    end

    tsrb_chain #(
        .DEPTH  (WINDOW_DEPTH),
        .FILL_W (FILL_W)
    ) u_chain (
        .i_clk    (i_clk),
        .i_ctrl   (w_ctrl),
        .i_fill   (r_fill),
        .o_head   (w_head),
        .o_second (w_second)
    );

    assign o_out.valid       = r_ov;
    assign o_out.kind        = r_kind;
    assign o_out.out_time    = r_otime;
    assign o_out.out_payload = r_opay;
    assign o_out.last        = r_last;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(WINDOW_DEPTH))
        else $error("fill count beyond window depth");

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> w_nonempty)
        else $error("batch emission from an empty chain");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill > FILL_W'(1)) |-> (w_head.tstamp <= w_second.tstamp))
        else $error("chain head out of time order");

    a_empty_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_in.action && !w_nonempty)
        |=> (r_ov && r_last && (r_kind == tsrb_pkg::KIND_EMPTY)))
        else $error("drain on empty window without empty marker");

    a_batch_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && !i_in.action && w_full) |=> (r_state == S_EMIT))
        else $error("insert into full window did not start batch");
`endif

endmodule

// ===== hdl/tsrb_cell.sv =====
// One slot of the sorted chain: holds an entry, shifts or inserts by neighbor data.
module tsrb_cell (
    input  logic                 i_clk,
    input  tsrb_pkg::t_cell_ctrl i_ctrl,
    input  logic                 i_valid,
    input  logic                 i_prev_after,
    input  tsrb_pkg::t_entry     i_left,
    input  tsrb_pkg::t_entry     i_right,
    output tsrb_pkg::t_entry     o_entry,
    output logic                 o_after
);

    tsrb_pkg::t_entry r_entry;
    tsrb_pkg::t_entry n_entry;

    // New key lands at or before this slot.
    assign o_after = !i_valid || (r_entry.tstamp > i_ctrl.key);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_ctrl.op)
            tsrb_pkg::OP_SHIFT: begin
                n_entry = i_right;
            end
            tsrb_pkg::OP_INSERT: begin
                if (o_after) begin
                    if (!i_prev_after) begin
                        n_entry.tstamp = i_ctrl.key;
                        n_entry.pay    = i_ctrl.pay;
                    end else begin
                        n_entry = i_left;
                    end
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ===== hdl/tsrb_chain.sv =====
// Row of sort cells, oldest entry in cell 0; occupancy follows the fill count.
module tsrb_chain #(
    parameter int DEPTH  = tsrb_pkg::DEF_WINDOW_DEPTH,
    parameter int FILL_W = $clog2(DEPTH + 1)
) (
    input  logic                 i_clk,
    input  tsrb_pkg::t_cell_ctrl i_ctrl,
    input  logic [FILL_W-1:0]    i_fill,
    output tsrb_pkg::t_entry     o_head,
    output tsrb_pkg::t_entry     o_second
);

    tsrb_pkg::t_entry w_entry [DEPTH];
    logic             w_after [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        tsrb_pkg::t_entry w_left;
        tsrb_pkg::t_entry w_right;
        logic             w_prev_after;
        logic             w_valid;

        assign w_valid = FILL_W'(i) < i_fill;

        if (i == 0) begin : g_first
            assign w_left       = w_entry[i];
            assign w_prev_after = 1'b0;
        end else begin : g_mid
            assign w_left       = w_entry[i-1];
            assign w_prev_after = w_after[i-1];
        end

        if (i == DEPTH - 1) begin : g_end
            assign w_right = w_entry[i];
        end else begin : g_inner
            assign w_right = w_entry[i+1];
        end

        tsrb_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (i_ctrl),
            .i_valid      (w_valid),
            .i_prev_after (w_prev_after),
            .i_left       (w_left),
            .i_right      (w_right),
            .o_entry      (w_entry[i]),
            .o_after      (w_after[i])
        );
    end

    assign o_head   = w_entry[0];
    assign o_second = w_entry[1];

endmodule
